// File: sv/spq_pkg.sv
// Shared types and constants for the stable priority ready queue.
// Depends on nothing; every other file of the block imports it.
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;
    localparam int OCC_W     = 5;

    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } ctrl_t;

endpackage

// File: sv/spq_if.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on spq_pkg for the field widths.
interface spq_req_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [ID_W-1:0]   proc_id;
    logic [PRIO_W-1:0] prio;

    modport source (output valid, action, proc_id, prio, input ready);
    modport sink   (input valid, action, proc_id, prio, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_prio;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, status, out_id, out_prio, occupancy, input ready);
    modport sink   (input valid, status, out_id, out_prio, occupancy, output ready);
endinterface

// File: sv/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts it to a neighbor.
// Depends on spq_pkg for the control struct and field widths.
module spq_cell (
    input  logic                      clk,
    input  spq_pkg::ctrl_t            ctrl,
    input  logic                      occupied,
    input  logic                      left_keep,
    input  logic [spq_pkg::ID_W-1:0]  left_id,
    input  logic [spq_pkg::PRIO_W-1:0] left_prio,
    input  logic [spq_pkg::ID_W-1:0]  right_id,
    input  logic [spq_pkg::PRIO_W-1:0] right_prio,
    output logic                      keep,
    output logic [spq_pkg::ID_W-1:0]  slot_id,
    output logic [spq_pkg::PRIO_W-1:0] slot_prio
);
    import spq_pkg::*;

    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;

    // An occupied slot of equal or higher priority stays ahead of a new entry.
    assign keep      = occupied && (prio_reg >= ctrl.prio);
    assign slot_id   = id_reg;
    assign slot_prio = prio_reg;

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ctrl.enq && !keep)
        begin
            if (left_keep)
            begin
                id_next   = ctrl.id;
                prio_next = ctrl.prio;
            end
            else
            begin
                id_next   = left_id;
                prio_next = left_prio;
            end
        end
        else if (ctrl.deq)
        begin
            id_next   = right_id;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

// File: sv/stable_priority_ready_queue.sv
// Channel    Role    Carries
// req        sink    action, proc_id, prio
// rsp        source  status, out_id, out_prio, occupancy
//
// One transaction is taken per cycle and answered in the next cycle from the
// response register; every slot compares against the new priority at once.
// Reset clears the fill count and the response valid flag; slot contents and
// response fields are not reset. A stalled response holds req.ready low until
// it is taken.
// Depends on spq_pkg, spq_if and spq_cell.
module stable_priority_ready_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_id_next;
    logic [PRIO_W-1:0] out_prio_reg;
    logic [PRIO_W-1:0] out_prio_next;
    logic [OCC_W-1:0]  occ_reg;

    logic              accept;
    logic              full;
    logic              empty;
    ctrl_t             ctrl;

    logic [ID_W-1:0]   cell_id   [DEPTH];
    logic [PRIO_W-1:0] cell_prio [DEPTH];
    logic [DEPTH-1:0]  cell_keep;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign accept = req.valid && req.ready;

    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign ctrl.enq  = accept && (req.action == ACT_ENQ) && !full;
    assign ctrl.deq  = accept && (req.action == ACT_DEQ) && !empty;
    assign ctrl.id   = req.proc_id;
    assign ctrl.prio = req.prio;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic              left_keep;
            logic [ID_W-1:0]   left_id;
            logic [PRIO_W-1:0] left_prio;
            logic [ID_W-1:0]   right_id;
            logic [PRIO_W-1:0] right_prio;

            if (g == 0)
            begin : g_head
                assign left_keep = 1'b1;
                assign left_id   = ctrl.id;
                assign left_prio = ctrl.prio;
            end
            else
            begin : g_body
                assign left_keep = cell_keep[g-1];
                assign left_id   = cell_id[g-1];
                assign left_prio = cell_prio[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign right_id   = cell_id[g];
                assign right_prio = cell_prio[g];
            end
            else
            begin : g_inner
                assign right_id   = cell_id[g+1];
                assign right_prio = cell_prio[g+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (count_reg > CNT_W'(g)),
                .left_keep  (left_keep),
                .left_id    (left_id),
                .left_prio  (left_prio),
                .right_id   (right_id),
                .right_prio (right_prio),
                .keep       (cell_keep[g]),
                .slot_id    (cell_id[g]),
                .slot_prio  (cell_prio[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        status_next   = ST_DONE;
        out_id_next   = '0;
        out_prio_next = '0;
        case (req.action)
            ACT_ENQ:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DEQ:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next    = count_reg - CNT_W'(1);
                    out_id_next   = cell_id[0];
                    out_prio_next = cell_prio[0];
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            out_id_reg   <= out_id_next;
            out_prio_reg <= out_prio_next;
            occ_reg      <= OCC_W'(count_next);
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.out_id    = out_id_reg;
    assign rsp.out_prio  = out_prio_reg;
    assign rsp.occupancy = occ_reg;

endmodule
